FILE: hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants for the line sequencer and its top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DELAY_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0] TPU_RESET   = 8'd1;
  localparam logic [7:0] LIMIT_RESET = 8'd250;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_WAITACK = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [2:0]         phase;
    logic [3:0]         bit_index;
    logic [7:0]         shift_byte;
    logic [DELAY_W-1:0] delay_left;
    logic [7:0]         poll_count;
    logic               scl;
    logic               sda;
    logic               drv;
    logic               fail_flag;
    logic               ack_choice;
    logic [7:0]         rx_last;
  } state_t;

endpackage

FILE: hw/rtl/i2cm_step.sv
// ----------------------------------------------------------------------------
// I2C master bit engine step logic
// Next-state logic for one tick: command accept, delay countdown and the
// line segments of start, stop, write, wait-ack and read.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::state_t cur,
  input  i2cm_pkg::item_t  item,
  input  logic [7:0]       ticks_per_us,
  input  logic [7:0]       ack_poll_limit,
  output i2cm_pkg::state_t nxt,
  output logic             done
);
  import i2cm_pkg::*;

  localparam logic [2:0] SEG0 = 3'd0;
  localparam logic [2:0] SEG1 = 3'd1;
  localparam logic [2:0] SEG2 = 3'd2;
  localparam logic [2:0] SEG3 = 3'd3;
  localparam logic [2:0] SEG4 = 3'd4;

  typedef struct packed {
    state_t st;
    logic   done;
  } step_t;

  logic [DELAY_W-1:0] tpu;
  logic [DELAY_W-1:0] d1;
  logic [DELAY_W-1:0] d2;
  logic [DELAY_W-1:0] d4;

  // Hold lengths are the reload value of the countdown, one less than the ticks.
  assign tpu = (ticks_per_us == 8'd0) ? DELAY_W'(1) : {2'b00, ticks_per_us};
  assign d1  = tpu - DELAY_W'(1);
  assign d2  = (tpu << 1) - DELAY_W'(1);
  assign d4  = (tpu << 2) - DELAY_W'(1);

  function automatic state_t finish(state_t s);
    s.cmd        = CMD_IDLE;
    s.phase      = SEG0;
    s.delay_left = '0;
    return s;
  endfunction

  function automatic state_t write_bit(state_t s, logic [DELAY_W-1:0] h);
    s.drv        = 1'b1;
    s.scl        = 1'b0;
    s.sda        = s.shift_byte[7];
    s.shift_byte = {s.shift_byte[6:0], 1'b0};
    s.delay_left = h;
    s.phase      = SEG1;
    return s;
  endfunction

  function automatic state_t read_low(state_t s, logic [DELAY_W-1:0] h);
    s.drv        = 1'b0;
    s.scl        = 1'b0;
    s.delay_left = h;
    s.phase      = SEG1;
    return s;
  endfunction

  function automatic state_t stop_first(state_t s, logic [2:0] nph, logic [DELAY_W-1:0] h);
    s.drv        = 1'b1;
    s.scl        = 1'b0;
    s.sda        = 1'b0;
    s.delay_left = h;
    s.phase      = nph;
    return s;
  endfunction

  function automatic step_t act(state_t s, logic sda, logic [7:0] limit,
                                logic [DELAY_W-1:0] h1, logic [DELAY_W-1:0] h2,
                                logic [DELAY_W-1:0] h4);
    step_t      r;
    logic [8:0] cnt;
    r.st   = s;
    r.done = 1'b0;
    cnt    = {1'b0, s.poll_count} + 9'd1;
    unique case (s.cmd)
      CMD_START: begin
        if (s.phase == SEG0) begin
          r.st.drv = 1'b1; r.st.sda = 1'b1; r.st.scl = 1'b1;
          r.st.delay_left = h4; r.st.phase = SEG1;
        end else if (s.phase == SEG1) begin
          r.st.sda = 1'b0; r.st.delay_left = h4; r.st.phase = SEG2;
        end else begin
          r.st.scl = 1'b0; r.st = finish(r.st); r.done = 1'b1;
        end
      end
      CMD_STOP: begin
        if (s.phase == SEG0) begin
          r.st = stop_first(s, SEG1, h4);
        end else if (s.phase == SEG1) begin
          r.st.scl = 1'b1; r.st.sda = 1'b1;
          r.st.delay_left = h4; r.st.phase = SEG2;
        end else begin
          r.st = finish(s); r.done = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (s.phase == SEG0) begin
          r.st = write_bit(s, h2);
        end else if (s.phase == SEG1) begin
          r.st.scl = 1'b1; r.st.delay_left = h2; r.st.phase = SEG2;
        end else if (s.phase == SEG2) begin
          r.st.scl = 1'b0; r.st.delay_left = h2;
          r.st.bit_index = s.bit_index + 4'd1; r.st.phase = SEG3;
        end else if (s.bit_index < 4'd8) begin
          r.st = write_bit(s, h2);
        end else begin
          r.st = finish(s); r.done = 1'b1;
        end
      end
      CMD_WAITACK: begin
        if (s.phase == SEG0) begin
          r.st.drv = 1'b0; r.st.delay_left = h1; r.st.phase = SEG1;
        end else if (s.phase == SEG1) begin
          r.st.scl = 1'b1; r.st.delay_left = h1;
          r.st.poll_count = '0; r.st.phase = SEG2;
        end else if (s.phase == SEG2) begin
          // One poll per tick; too many high samples turn into a stop.
          if (!sda) begin
            r.st.scl = 1'b0; r.st.fail_flag = 1'b0;
            r.st = finish(r.st); r.done = 1'b1;
          end else if (cnt > {1'b0, limit}) begin
            r.st = stop_first(s, SEG3, h4);
          end else begin
            r.st.poll_count = cnt[7:0];
          end
        end else if (s.phase == SEG3) begin
          r.st.scl = 1'b1; r.st.sda = 1'b1;
          r.st.delay_left = h4; r.st.phase = SEG4;
        end else begin
          r.st.fail_flag = 1'b1; r.st = finish(r.st); r.done = 1'b1;
        end
      end
      CMD_READ: begin
        if (s.phase == SEG0) begin
          r.st = read_low(s, h2);
        end else if (s.phase == SEG1) begin
          r.st.scl = 1'b1;
          r.st.shift_byte = {s.shift_byte[6:0], sda};
          r.st.bit_index = s.bit_index + 4'd1;
          r.st.delay_left = h1; r.st.phase = SEG2;
        end else if (s.phase == SEG2) begin
          if (s.bit_index < 4'd8) begin
            r.st = read_low(s, h2);
          end else begin
            r.st.scl = 1'b0; r.st.drv = 1'b1; r.st.sda = ~s.ack_choice;
            r.st.delay_left = h2; r.st.phase = SEG3;
          end
        end else if (s.phase == SEG3) begin
          r.st.scl = 1'b1; r.st.delay_left = h2; r.st.phase = SEG4;
        end else begin
          r.st.scl = 1'b0; r.st.rx_last = s.shift_byte;
          r.st = finish(r.st); r.done = 1'b1;
        end
      end
      default: begin
        r.st = finish(s); r.done = 1'b1;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    state_t s;
    step_t  r;
    s      = cur;
    r.st   = cur;
    r.done = 1'b0;
    if (cur.cmd == CMD_IDLE) begin
      if (item.req_type >= 3'd1 && item.req_type <= 3'd5) begin
        s.cmd       = cmd_t'(item.req_type);
        s.phase     = SEG0;
        s.bit_index = '0;
        s.poll_count = '0;
        if (s.cmd == CMD_WRITE) begin
          s.shift_byte = item.tx_byte;
        end
        if (s.cmd == CMD_READ) begin
          s.shift_byte = '0;
          s.ack_choice = item.send_ack;
        end
        r = act(s, item.sda_in, ack_poll_limit, d1, d2, d4);
      end
    end else if (cur.delay_left != '0) begin
      r.st.delay_left = cur.delay_left - DELAY_W'(1);
    end else begin
      r = act(cur, item.sda_in, ack_poll_limit, d1, d2, d4);
    end
    nxt  = r.st;
    done = r.done;
  end

endmodule

FILE: hw/rtl/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Tick-driven line sequencer for one bit-banged I2C master.
// ----------------------------------------------------------------------------
// Usage: every input beat is one time tick. s_tuser carries the request code
// (0 tick only, 1 start, 2 stop, 3 write byte, 4 wait ack, 5 read byte) and
// s_tdata the byte to send, the ACK choice and the sampled SDA level. A
// request is only taken on a tick that finds the engine idle.
// Every input beat yields exactly one output beat with the SCL and SDA drive,
// busy, done, the last received byte and the ack-fail flag.
// Beats pass an input register and then the step logic into an output
// register: one beat per cycle sustained while the receiver keeps m_tready
// high. The one-tick step logic is the only loop.
// If the receiver stalls, the output register holds and the input register
// fills; s_tready then drops until the result is taken, and no beat is lost.
// Reset puts the lines to SCL high, SDA high and driven, idle, registers to
// ticks_per_us 1 and ack_poll_limit 250. Configuration writes via cfg_we
// take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [2:0]                         s_tuser,  // req_type
  input  logic [i2cm_pkg::IN_TDATA_W-1:0]    s_tdata,  // tx_byte, send_ack, sda_in
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // scl_level, sda_level, sda_driving, busy_res, done_res, rx_byte, ack_fail
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cm_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import i2cm_pkg::*;

  logic       ticks_valid_unused;
  logic [7:0] ticks_per_us;
  logic [7:0] ack_poll_limit;

  logic   s1_valid;
  item_t  s1_item;
  logic   advance;

  state_t st;
  state_t st_next;
  logic   done;

  assign ticks_valid_unused = 1'b0;
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us   <= TPU_RESET;
      ack_poll_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_US:   ticks_per_us   <= cfg_data;
        REG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.req_type <= s_tuser;
      s1_item.tx_byte  <= s_tdata[7:0];
      s1_item.send_ack <= s_tdata[8];
      s1_item.sda_in   <= s_tdata[9];
    end
  end

  i2cm_step u_step (
    .cur            (st),
    .item           (s1_item),
    .ticks_per_us   (ticks_per_us),
    .ack_poll_limit (ack_poll_limit),
    .nxt            (st_next),
    .done           (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.cmd        <= CMD_IDLE;
      st.phase      <= '0;
      st.bit_index  <= '0;
      st.shift_byte <= '0;
      st.delay_left <= '0;
      st.poll_count <= '0;
      st.scl        <= 1'b1;
      st.sda        <= 1'b1;
      st.drv        <= 1'b1;
      st.fail_flag  <= 1'b0;
      st.ack_choice <= 1'b0;
      st.rx_last    <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {ticks_valid_unused, ticks_valid_unused,
                  st_next.fail_flag, st_next.rx_last, done,
                  (st_next.cmd != CMD_IDLE), st_next.drv,
                  (st_next.drv & st_next.sda), st_next.scl};
    end
  end

`ifndef SYNTHESIS
  // A finished command never reports busy on the same beat.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
    else $error("done and busy both set in one result beat");

  // The hold countdown only runs while a command is held.
  a_delay_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    (st.delay_left != '0) |-> (st.cmd != CMD_IDLE))
    else $error("delay pending with no command held");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase <= 3'd4)
    else $error("sequencer phase out of range");

  // A waiting input beat is kept until the step logic takes it.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("input register lost a beat");

  // Sequencer state only moves when a beat goes through.
  a_state_stalls: assert property (@(posedge clk) disable iff (rst)
    (!advance && !$past(rst)) |=> $stable(st))
    else $error("state changed without a beat");
`endif

endmodule
